>>> hdl/pca_pkg.sv
// Package for the PCA subspace projection unit.
// Holds field widths, function codes, sequencer states and the operation
// structs of the top level and the arithmetic unit; the checker uses the widths and function codes.
`default_nettype none

package pca_pkg;

  localparam int FUNC_W      = 2;
  localparam int INDEX_W     = 10;
  localparam int COLUMN_W    = 6;
  localparam int VALUE_W     = 16;
  localparam int KEEP_W      = 7;
  localparam int COEF_IDX_W  = 6;
  localparam int COEF_W      = 32;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 64;
  localparam int DIFF_W      = 17;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEAN   = 2'd0,
    FUNC_BASIS  = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MAC,
    S_ENER,
    S_DRAIN,
    E_READ,
    E_COEF,
    E_WAIT,
    E_PUSH
  } state_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_ENERGY,
    OP_RESID
  } op_kind_t;

  typedef struct packed {
    logic                     vld;
    op_kind_t                 kind;
    logic [COEF_IDX_W-1:0]    tag;
    logic                     chain;
    logic                     sub;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [ACC_W-1:0]  acc;
  } mac_op_t;

  typedef struct packed {
    logic                    vld;
    op_kind_t                kind;
    logic [COEF_IDX_W-1:0]   tag;
    logic signed [ACC_W-1:0] value;
  } mac_res_t;

endpackage

`default_nettype wire

>>> hdl/pca_ifs.sv
// Channel interfaces of the PCA subspace projection unit: input items,
// result items and the configuration write channel.
// Depends on pca_pkg for the field widths.
`default_nettype none

interface pca_in_if;
  logic                               valid;
  logic                               ready;
  logic [pca_pkg::FUNC_W-1:0]         func;
  logic [pca_pkg::INDEX_W-1:0]        index;
  logic [pca_pkg::COLUMN_W-1:0]       column;
  logic signed [pca_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source(output valid, func, index, column, value, last, input ready);
  modport sink(input valid, func, index, column, value, last, output ready);
endinterface

interface pca_out_if;
  logic                                valid;
  logic                                ready;
  logic [pca_pkg::COEF_IDX_W-1:0]      coef_index;
  logic signed [pca_pkg::COEF_W-1:0]   coefficient;
  logic signed [pca_pkg::ACC_W-1:0]    residual;
  logic                                final_res;
  logic                                overflow;

  modport source(output valid, coef_index, coefficient, residual, final_res, overflow,
                 input ready);
  modport sink(input valid, coef_index, coefficient, residual, final_res, overflow,
               output ready);
endinterface

interface pca_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pca_pkg::KEEP_W-1:0]  keep_count;

  modport source(output valid, keep_count, input ready);
  modport sink(input valid, keep_count, output ready);
endinterface

`default_nettype wire

>>> hdl/pca_subspace_projection_unit.sv
// Top level of the PCA subspace projection unit: stores, sequencer and
// output register around the shared multiply-accumulate unit.
// Depends on pca_pkg, the channel interfaces and pca_mac_unit.
`default_nettype none

// A sample element occupies the block while every coefficient update, and
// then the energy update, passes one at a time through the single shared
// multiplier, which issues one operation per cycle. On the element marked
// last the block then emits the kept coefficients one by one, since each
// squared coefficient is subtracted from the running residual through the
// same multiplier; a stall of the result channel holds the emission. The
// input channel is not ready while a sample element or an emission is in
// progress; the final result may still wait in the output register while
// the next transaction is accepted. There is no clearing pass after reset.
module pca_subspace_projection_unit #(
  parameter int DIMS_MAX = 256,
  parameter int KEEP_MAX = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pca_in_if.sink     in_ch,
  pca_out_if.source  out_ch,
  pca_cfg_if.sink    cfg_ch
);

  localparam int AW  = $clog2(DIMS_MAX);
  localparam int CW  = $clog2(DIMS_MAX + 1);
  localparam int KW  = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
  localparam int KCW = $clog2(KEEP_MAX + 1);
  localparam int BW  = $clog2(DIMS_MAX * KEEP_MAX);

  localparam int VW = pca_pkg::VALUE_W;
  localparam int DW = pca_pkg::DIFF_W;
  localparam int XW = pca_pkg::COEF_W;
  localparam int AC = pca_pkg::ACC_W;

  logic signed [VW-1:0] mean_mem  [DIMS_MAX];
  logic signed [VW-1:0] basis_mem [DIMS_MAX*KEEP_MAX];
  logic signed [AC-1:0] acc_mem   [KEEP_MAX];

  pca_pkg::state_t state_r, state_nxt;

  logic [pca_pkg::KEEP_W-1:0] keep_r;
  logic [pca_pkg::KEEP_W-1:0] keep_eff;

  logic [CW-1:0]        count_r, count_nxt;
  logic                 too_many_r, too_many_nxt;
  logic signed [AC-1:0] energy_r, energy_nxt;
  logic [KCW-1:0]       idx_r, idx_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic                 last_r, last_nxt;
  logic signed [DW-1:0] diff_r, diff_nxt;
  logic signed [XW-1:0] coef_r, coef_nxt;
  logic                 v1_r, v1_nxt;
  logic [KW-1:0]        tag1_r, tag1_nxt;

  logic signed [VW-1:0] mean_q_r;
  logic signed [VW-1:0] basis_q_r;
  logic signed [AC-1:0] acc_q_r;

  logic                            out_vld_r, out_vld_nxt;
  logic [pca_pkg::COEF_IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic signed [XW-1:0]            out_coef_r, out_coef_nxt;
  logic signed [AC-1:0]            out_res_r, out_res_nxt;
  logic                            out_fin_r, out_fin_nxt;
  logic                            out_ovf_r, out_ovf_nxt;

  logic in_acc;
  logic mean_we;
  logic basis_we;
  logic acc_we;
  logic out_free;
  logic fin;
  logic is_full;
  logic [BW-1:0] basis_waddr;
  logic [BW-1:0] basis_raddr;
  logic signed [XW-1:0] coef_w;

  pca_pkg::mac_op_t  mac_op;
  pca_pkg::mac_res_t mac_res;

  function automatic logic signed [XW-1:0] round_sat(input logic signed [AC-1:0] a);
    logic signed [AC:0]    t;
    logic signed [AC-15:0] s;
    t = {a[AC-1], a} + 49'sd16384;
    s = t[AC:15];
    if (s > 34'sh0_7FFF_FFFF) begin
      round_sat = 32'sh7FFF_FFFF;
    end else if (s < -34'sh0_8000_0000) begin
      round_sat = 32'sh8000_0000;
    end else begin
      round_sat = s[XW-1:0];
    end
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign is_full  = (count_r == CW'(DIMS_MAX));
  assign fin      = ((pca_pkg::KEEP_W'(idx_r) + 7'd1) == keep_eff);
  assign coef_w   = round_sat(acc_q_r);

  assign mean_we  = in_acc && (in_ch.func == pca_pkg::FUNC_MEAN) &&
                    ({1'b0, in_ch.index} < 11'(DIMS_MAX));
  assign basis_we = in_acc && (in_ch.func == pca_pkg::FUNC_BASIS) &&
                    ({1'b0, in_ch.index} < 11'(DIMS_MAX)) &&
                    ({1'b0, in_ch.column} < 7'(KEEP_MAX));
  assign acc_we   = mac_res.vld && (mac_res.kind == pca_pkg::OP_ACC);

  assign basis_waddr = BW'(in_ch.index) * BW'(KEEP_MAX) + BW'(in_ch.column);
  assign basis_raddr = BW'(count_r) * BW'(KEEP_MAX) + BW'(idx_r);

  always_comb begin
    if (keep_r == '0) begin
      keep_eff = 7'd1;
    end else if (keep_r > 7'(KEEP_MAX)) begin
      keep_eff = 7'(KEEP_MAX);
    end else begin
      keep_eff = keep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mean_we) begin
      mean_mem[in_ch.index[AW-1:0]] <= in_ch.value;
    end
    mean_q_r <= mean_mem[count_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (basis_we) begin
      basis_mem[basis_waddr] <= in_ch.value;
    end
    basis_q_r <= basis_mem[basis_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[mac_res.tag[KW-1:0]] <= mac_res.value;
    end
    acc_q_r <= acc_mem[idx_r[KW-1:0]];
  end

  always_comb begin
    mac_op.vld   = 1'b0;
    mac_op.kind  = pca_pkg::OP_ACC;
    mac_op.tag   = pca_pkg::COEF_IDX_W'(tag1_r);
    mac_op.chain = 1'b0;
    mac_op.sub   = 1'b0;
    mac_op.a     = {{(XW - DW){diff_r[DW-1]}}, diff_r};
    mac_op.b     = {{(XW - VW){basis_q_r[VW-1]}}, basis_q_r};
    mac_op.acc   = (count_r == '0) ? '0 : acc_q_r;
    if (v1_r) begin
      mac_op.vld = 1'b1;
    end else if (state_r == pca_pkg::S_ENER) begin
      mac_op.vld  = 1'b1;
      mac_op.kind = pca_pkg::OP_ENERGY;
      mac_op.b    = {{(XW - DW){diff_r[DW-1]}}, diff_r};
      mac_op.acc  = energy_r;
    end else if (state_r == pca_pkg::E_COEF) begin
      mac_op.vld   = 1'b1;
      mac_op.kind  = pca_pkg::OP_RESID;
      mac_op.chain = (idx_r != '0);
      mac_op.sub   = 1'b1;
      mac_op.a     = coef_w;
      mac_op.b     = coef_w;
      mac_op.acc   = energy_r;
    end
  end

  pca_mac_unit u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .res   (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pca_pkg::S_IDLE: begin
        if (in_acc && (in_ch.func == pca_pkg::FUNC_SAMPLE)) begin
          if (!is_full) begin
            state_nxt = pca_pkg::S_DIFF;
          end else if (in_ch.last) begin
            state_nxt = pca_pkg::E_READ;
          end
        end
      end
      pca_pkg::S_DIFF: state_nxt = pca_pkg::S_MAC;
      pca_pkg::S_MAC: begin
        if (idx_r == KCW'(KEEP_MAX)) begin
          state_nxt = pca_pkg::S_ENER;
        end
      end
      pca_pkg::S_ENER: state_nxt = pca_pkg::S_DRAIN;
      pca_pkg::S_DRAIN: begin
        if (mac_res.vld && (mac_res.kind == pca_pkg::OP_ENERGY)) begin
          state_nxt = last_r ? pca_pkg::E_READ : pca_pkg::S_IDLE;
        end
      end
      pca_pkg::E_READ: state_nxt = pca_pkg::E_COEF;
      pca_pkg::E_COEF: state_nxt = pca_pkg::E_WAIT;
      pca_pkg::E_WAIT: state_nxt = pca_pkg::E_PUSH;
      pca_pkg::E_PUSH: begin
        if (out_free) begin
          state_nxt = fin ? pca_pkg::S_IDLE : pca_pkg::E_READ;
        end
      end
      default: state_nxt = pca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    too_many_nxt = too_many_r;
    energy_nxt   = energy_r;
    idx_nxt      = idx_r;
    val_nxt      = val_r;
    last_nxt     = last_r;
    diff_nxt     = diff_r;
    coef_nxt     = coef_r;
    v1_nxt       = 1'b0;
    tag1_nxt     = idx_r[KW-1:0];
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_idx_nxt  = out_idx_r;
    out_coef_nxt = out_coef_r;
    out_res_nxt  = out_res_r;
    out_fin_nxt  = out_fin_r;
    out_ovf_nxt  = out_ovf_r;
    case (state_r)
      pca_pkg::S_IDLE: begin
        idx_nxt = '0;
        if (in_acc && (in_ch.func == pca_pkg::FUNC_SAMPLE)) begin
          val_nxt  = in_ch.value;
          last_nxt = in_ch.last;
          if (is_full) begin
            too_many_nxt = 1'b1;
          end
        end
      end
      pca_pkg::S_DIFF: begin
        diff_nxt = {val_r[VW-1], val_r} - {mean_q_r[VW-1], mean_q_r};
        idx_nxt  = '0;
      end
      pca_pkg::S_MAC: begin
        if (idx_r != KCW'(KEEP_MAX)) begin
          v1_nxt  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      pca_pkg::S_DRAIN: begin
        idx_nxt = '0;
        if (mac_res.vld && (mac_res.kind == pca_pkg::OP_ENERGY)) begin
          energy_nxt = mac_res.value;
          count_nxt  = count_r + 1'b1;
        end
      end
      pca_pkg::E_COEF: begin
        coef_nxt = coef_w;
      end
      pca_pkg::E_PUSH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = pca_pkg::COEF_IDX_W'(idx_r);
          out_coef_nxt = coef_r;
          out_res_nxt  = fin ? mac_res.value : '0;
          out_fin_nxt  = fin;
          out_ovf_nxt  = too_many_r;
          if (fin) begin
            count_nxt    = '0;
            too_many_nxt = 1'b0;
            energy_nxt   = '0;
            idx_nxt      = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pca_pkg::S_IDLE;
      keep_r     <= pca_pkg::KEEP_RESET;
      count_r    <= '0;
      too_many_r <= 1'b0;
      energy_r   <= '0;
      idx_r      <= '0;
      v1_r       <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_ch.valid) begin
        keep_r <= cfg_ch.keep_count;
      end
      count_r    <= count_nxt;
      too_many_r <= too_many_nxt;
      energy_r   <= energy_nxt;
      idx_r      <= idx_nxt;
      v1_r       <= v1_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    diff_r     <= diff_nxt;
    coef_r     <= coef_nxt;
    tag1_r     <= tag1_nxt;
    out_idx_r  <= out_idx_nxt;
    out_coef_r <= out_coef_nxt;
    out_res_r  <= out_res_nxt;
    out_fin_r  <= out_fin_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_ch.ready        = (state_r == pca_pkg::S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.coef_index  = out_idx_r;
  assign out_ch.coefficient = out_coef_r;
  assign out_ch.residual    = out_res_r;
  assign out_ch.final_res   = out_fin_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

`default_nettype wire

>>> hdl/pca_mac_unit.sv
// Shared two-stage multiply and saturating accumulate unit.
// Stage one registers a 32 by 32 signed product, stage two adds or
// subtracts it against an accumulator or its own last result. Uses pca_pkg.
`default_nettype none

module pca_mac_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pca_pkg::mac_op_t  op,
  output pca_pkg::mac_res_t      res
);

  localparam int SUM_W = pca_pkg::PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_MAX = 66'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - 66'sd1;

  logic                                s1_vld_r;
  pca_pkg::op_kind_t                   s1_kind_r;
  logic [pca_pkg::COEF_IDX_W-1:0]      s1_tag_r;
  logic                                s1_chain_r;
  logic                                s1_sub_r;
  logic signed [pca_pkg::PROD_W-1:0]   s1_prod_r;
  logic signed [pca_pkg::ACC_W-1:0]    s1_acc_r;

  logic                                res_vld_r;
  pca_pkg::op_kind_t                   res_kind_r;
  logic [pca_pkg::COEF_IDX_W-1:0]      res_tag_r;
  logic signed [pca_pkg::ACC_W-1:0]    res_val_r;
  logic signed [pca_pkg::ACC_W-1:0]    res_val_nxt;

  logic signed [pca_pkg::ACC_W-1:0]    base;
  logic signed [SUM_W-1:0]             sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= op.vld;
      res_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (op.vld) begin
      s1_kind_r  <= op.kind;
      s1_tag_r   <= op.tag;
      s1_chain_r <= op.chain;
      s1_sub_r   <= op.sub;
      s1_prod_r  <= op.a * op.b;
      s1_acc_r   <= op.acc;
    end
    if (s1_vld_r) begin
      res_kind_r <= s1_kind_r;
      res_tag_r  <= s1_tag_r;
      res_val_r  <= res_val_nxt;
    end
  end

  always_comb begin
    base = s1_chain_r ? res_val_r : s1_acc_r;
    if (s1_sub_r) begin
      sum = {{(SUM_W - pca_pkg::ACC_W){base[pca_pkg::ACC_W-1]}}, base}
          - {{2{s1_prod_r[pca_pkg::PROD_W-1]}}, s1_prod_r};
    end else begin
      sum = {{(SUM_W - pca_pkg::ACC_W){base[pca_pkg::ACC_W-1]}}, base}
          + {{2{s1_prod_r[pca_pkg::PROD_W-1]}}, s1_prod_r};
    end
    if (sum > SAT_MAX) begin
      res_val_nxt = SAT_MAX[pca_pkg::ACC_W-1:0];
    end else if (sum < SAT_MIN) begin
      res_val_nxt = SAT_MIN[pca_pkg::ACC_W-1:0];
    end else begin
      res_val_nxt = sum[pca_pkg::ACC_W-1:0];
    end
  end

  assign res.vld   = res_vld_r;
  assign res.kind  = res_kind_r;
  assign res.tag   = res_tag_r;
  assign res.value = res_val_r;

endmodule

`default_nettype wire

>>> hdl/pca_checker.sv
// Port-level checker for the PCA subspace projection unit and the bind
// that attaches it to the top level. Depends on pca_pkg.
`default_nettype none

module pca_port_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [pca_pkg::FUNC_W-1:0]         in_func,
  input wire logic                               in_last,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [pca_pkg::COEF_W-1:0]  out_coefficient,
  input wire logic signed [pca_pkg::ACC_W-1:0]   out_residual,
  input wire logic                               out_final_res
);

  // The closing element of a sample always leads to an emission.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == pca_pkg::FUNC_SAMPLE) && in_last |=> !in_ready)
    else $error("input ready after the closing element of a sample");

  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |-> (out_residual == '0))
    else $error("residual not zero on a non-final result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coefficient))
    else $error("stalled result transaction changed");

  // While a non-final result is shown, more coefficients follow, so the input stays closed.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |-> !in_ready)
    else $error("input ready in the middle of an emission");

endmodule

bind pca_subspace_projection_unit pca_port_checker u_pca_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_func         (in_ch.func),
  .in_last         (in_ch.last),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_coefficient (out_ch.coefficient),
  .out_residual    (out_ch.residual),
  .out_final_res   (out_ch.final_res)
);

`default_nettype wire
